### hw/rtl/chm_pkg.sv
package chm_pkg;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_SPARE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ABSENT  = 2'd1,
		ST_PRESENT = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_READ,
		S_CMP,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture request, start head read
		logic head_rd;  // start chain walk from the captured bucket head
		logic rd;       // read current entry
		logic step;     // advance to next link
		logic finish;   // commit and present result
	} chm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cur_valid;
		logic key_match;
		logic steps_done;
	} chm_sts_t;

endpackage

### hw/rtl/chm_ctrl.sv
module chm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  chm_pkg::chm_sts_t sts,
	output chm_pkg::chm_cmd_t cmd
);

	chm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			chm_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = chm_pkg::S_HEAD;
				end
			end
			chm_pkg::S_HEAD: begin
				cmd.head_rd = 1'b1;
				state_d = chm_pkg::S_READ;
			end
			chm_pkg::S_READ: begin
				if (sts.cur_valid && !sts.steps_done) begin
					cmd.rd = 1'b1;
					state_d = chm_pkg::S_CMP;
				end else begin
					state_d = chm_pkg::S_DONE;
				end
			end
			chm_pkg::S_CMP: begin
				if (sts.key_match) begin
					state_d = chm_pkg::S_DONE;
				end else begin
					cmd.step = 1'b1;
					state_d = chm_pkg::S_READ;
				end
			end
			chm_pkg::S_DONE: begin
				cmd.finish = 1'b1;
				state_d = chm_pkg::S_IDLE;
			end
			default: state_d = chm_pkg::S_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chm_pkg::S_IDLE && start) |=> busy)
		else $error("request not taken");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !busy)
		else $error("not idle after finish");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.head_rd, cmd.rd, cmd.step, cmd.finish}))
		else $error("commands overlap");

endmodule

### hw/rtl/chm_datapath.sv
module chm_datapath #(
	parameter int CAPACITY    = 256,
	parameter int NUM_BUCKETS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  chm_pkg::chm_cmd_t cmd,
	output chm_pkg::chm_sts_t sts,
	input  logic [1:0]        action,
	input  logic [31:0]       lookup_key,
	input  logic [31:0]       entry_value,
	output logic              done,
	output logic [1:0]        status,
	output logic [31:0]       found_value,
	output logic [8:0]        item_count
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [31:0]  key_mem [CAPACITY];
	logic [31:0]  val_mem [CAPACITY];
	logic [IW:0]  link_mem [CAPACITY];   // msb set: end of chain
	logic [IW:0]  head_mem [NUM_BUCKETS];
	logic [IW-1:0] free_mem [CAPACITY];
	logic [NUM_BUCKETS-1:0] head_vld_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] fill_q;   // lowest stack slot written since reset

	logic [1:0]   act_q;
	logic [31:0]  key_q, val_q;
	logic [BW-1:0] bkt_q;
	logic [IW:0]  head_rd_q, cur_q, prev_q, free_top_q;
	logic [31:0]  rkey_q, rval_q;
	logic [IW:0]  rlink_q;
	logic [CW-1:0] steps_q;
	logic [1:0]   status_q;
	logic [31:0]  found_q;
	logic         done_q;
	logic         head_v_q;

	logic [31:0]  bkt_full;
	logic [BW-1:0] bkt_d;
	logic [CW-1:0] top;
	logic         top_fresh;

	assign bkt_full = lookup_key % NUM_BUCKETS;
	assign bkt_d = BW'(bkt_full);
	assign top = CW'(CAPACITY - 1) - total_q;
	// stack slots below fill count were never written; the slot number is the free index
	assign top_fresh = (top < fill_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			key_q <= lookup_key;
			val_q <= entry_value;
			bkt_q <= bkt_d;
			head_rd_q <= head_mem[bkt_d];
			head_v_q <= head_vld_q[bkt_d];
			free_top_q <= {1'b0, free_mem[top[IW-1:0]]};
		end
		if (cmd.rd) begin
			rkey_q <= key_mem[cur_q[IW-1:0]];
			rval_q <= val_mem[cur_q[IW-1:0]];
			rlink_q <= link_mem[cur_q[IW-1:0]];
		end
	end

	assign sts.cur_valid = !cur_q[IW];
	assign sts.key_match = (rkey_q == key_q);
	assign sts.steps_done = (steps_q >= CW'(CAPACITY));

	logic [IW-1:0] new_e;
	assign new_e = top_fresh ? top[IW-1:0] : free_top_q[IW-1:0];

	// hit flag: match seen while a valid entry was compared
	logic cmp_hit;
	assign cmp_hit = sts.key_match && sts.cur_valid;
	logic in_cmp_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cmp_q <= 1'b0;
		end else begin
			in_cmp_q <= cmd.rd;
		end
	end
	logic hit_r_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_r_q <= 1'b0;
		end else if (cmd.head_rd) begin
			hit_r_q <= 1'b0;
		end else if (in_cmp_q && cmp_hit) begin
			hit_r_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
			total_q <= '0;
			fill_q <= CW'(CAPACITY);
			done_q <= 1'b0;
			cur_q <= '1;
			prev_q <= '1;
			steps_q <= '0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.head_rd) begin
				cur_q <= head_v_q ? head_rd_q : {1'b1, IW'(0)};
				prev_q <= {1'b1, IW'(0)};
				steps_q <= '0;
			end
			if (cmd.rd) begin
				steps_q <= steps_q + CW'(1);
			end
			if (cmd.step) begin
				prev_q <= cur_q;
				cur_q <= rlink_q;
			end
			if (cmd.finish) begin
				unique case (act_q)
					chm_pkg::ACT_INSERT: begin
						if (!hit_r_q && total_q < CW'(CAPACITY)) begin
							head_vld_q[bkt_q] <= 1'b1;
							total_q <= total_q + CW'(1);
						end
					end
					chm_pkg::ACT_REMOVE: begin
						if (hit_r_q) begin
							if (prev_q[IW]) begin
								head_vld_q[bkt_q] <= !rlink_q[IW];
							end
							if (total_q != '0) begin
								total_q <= total_q - CW'(1);
								if (top + CW'(1) < fill_q) begin
									fill_q <= top + CW'(1);
								end
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// memory writes at commit
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (act_q == chm_pkg::ACT_INSERT && !hit_r_q && total_q < CW'(CAPACITY)) begin
				key_mem[new_e] <= key_q;
				val_mem[new_e] <= val_q;
				link_mem[new_e] <= head_v_q ? head_rd_q : {1'b1, IW'(0)};
				head_mem[bkt_q] <= {1'b0, new_e};
			end
			if (act_q == chm_pkg::ACT_REMOVE && hit_r_q) begin
				if (prev_q[IW]) begin
					head_mem[bkt_q] <= rlink_q;
				end else begin
					link_mem[prev_q[IW-1:0]] <= rlink_q;
				end
				if (total_q != '0) begin
					free_mem[IW'(CW'(CAPACITY) - total_q)] <= cur_q[IW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_q <= '0;
			status_q <= chm_pkg::ST_ABSENT;
			unique case (act_q)
				chm_pkg::ACT_INSERT: begin
					if (hit_r_q) status_q <= chm_pkg::ST_PRESENT;
					else if (total_q >= CW'(CAPACITY)) status_q <= chm_pkg::ST_FULL;
					else status_q <= chm_pkg::ST_OK;
				end
				default: begin
					if (hit_r_q) begin
						status_q <= chm_pkg::ST_OK;
						found_q <= rval_q;
					end
				end
			endcase
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign found_value = found_q;
	assign item_count = 9'(total_q);

	assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(CAPACITY))
		else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> done)
		else $error("no result after commit");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == chm_pkg::ST_FULL) |-> item_count == 9'(CAPACITY))
		else $error("full flagged early");

endmodule

### hw/rtl/chained_hash_map_engine.sv
// a request passes load, head, then read and compare per chain entry, then finish;
// done is registered after finish, and a key match ends the chain walk early
// one request at a time; the next start can be taken while done is high
// busy goes high after the accepted start and stays high until the done strobe
// results show for one cycle on done; the receiver cannot stall
// reset: all buckets empty, free list full, count zero
module chained_hash_map_engine #(
	parameter int CAPACITY    = 256,
	parameter int NUM_BUCKETS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] lookup_key,
	input  logic [31:0] entry_value,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] found_value,
	output logic [8:0]  item_count
);

	chm_pkg::chm_cmd_t cmd;
	chm_pkg::chm_sts_t sts;

	chm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	chm_datapath #(.CAPACITY(CAPACITY), .NUM_BUCKETS(NUM_BUCKETS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.action(action), .lookup_key(lookup_key), .entry_value(entry_value),
		.done(done), .status(status), .found_value(found_value),
		.item_count(item_count)
	);

endmodule
